[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/minv4_pkg.sv]
// ----------------------------------------------------------------------------
// minv4_pkg
// Types, command/status structs and cofactor address table for the inverter.
// ----------------------------------------------------------------------------
package minv4_pkg;

    localparam int NUM_ELEM = 16;
    localparam int ADDR_W   = 4;
    localparam int NUM_TERM = 6;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_TRD,
        ST_TMUL,
        ST_TLATCH,
        ST_TML0,
        ST_TML1,
        ST_TACC1,
        ST_CWR,
        ST_DRD,
        ST_DMUL,
        ST_DACC,
        ST_DCHK,
        ST_SING,
        ST_VRD,
        ST_VLOAD,
        ST_VCMP,
        ST_VSTEP,
        ST_VOUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MUL_ELEM,
        MUL_MLIMB,
        MUL_CLIMB
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef struct packed {
        mul_sel_t          mul_sel;
        logic [1:0]        limb;
        acc_op_t           acc_op;
        logic              elem_we;
        logic [ADDR_W-1:0] elem_addr;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
        logic              cof_we;
        logic [ADDR_W-1:0] cof_waddr;
        logic [ADDR_W-1:0] cof_raddr;
        logic              latch_m;
        logic              det_latch;
        logic              div_load;
        logic              div_start;
        logic              div_step;
        logic              out_load;
        logic              out_singular;
        logic              out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic det_zero;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic [ADDR_W-1:0] c;
        logic              neg;
    } term_info_t;

    // Element addresses of one triple product of the 3x3 minor for
    // adjugate entry k (row-major); the entry is cofactor(row k[1:0], col k[3:2]).
    function automatic term_info_t term_info(input logic [3:0] k, input logic [2:0] t);
        logic [1:0] rs [3];
        logic [1:0] cs [3];
        logic [1:0] row_del;
        logic [1:0] col_del;
        logic [1:0] oc;
        logic [1:0] bc;
        logic [1:0] cc;
        logic       sgn;
        term_info_t info;
        row_del = k[1:0];
        col_del = k[3:2];
        for (int n = 0; n < 3; n++)
        begin
            rs[n] = (2'(n) < row_del) ? 2'(n) : 2'(n + 1);
            cs[n] = (2'(n) < col_del) ? 2'(n) : 2'(n + 1);
        end
        case (t)
            3'd0:    begin oc = 2'd0; bc = 2'd1; cc = 2'd2; sgn = 1'b0; end
            3'd1:    begin oc = 2'd0; bc = 2'd2; cc = 2'd1; sgn = 1'b1; end
            3'd2:    begin oc = 2'd1; bc = 2'd0; cc = 2'd2; sgn = 1'b1; end
            3'd3:    begin oc = 2'd1; bc = 2'd2; cc = 2'd0; sgn = 1'b0; end
            3'd4:    begin oc = 2'd2; bc = 2'd0; cc = 2'd1; sgn = 1'b0; end
            3'd5:    begin oc = 2'd2; bc = 2'd1; cc = 2'd0; sgn = 1'b1; end
            default: begin oc = 2'd0; bc = 2'd1; cc = 2'd2; sgn = 1'b0; end
        endcase
        info.a   = {rs[0], cs[oc]};
        info.b   = {rs[1], cs[bc]};
        info.c   = {rs[2], cs[cc]};
        info.neg = sgn ^ row_del[0] ^ col_del[0];
        return info;
    endfunction

endpackage

[rtl/minv4_ram.sv]
// ----------------------------------------------------------------------------
// minv4_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module minv4_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/minv4_dpath.sv]
// ----------------------------------------------------------------------------
// minv4_dpath
// Element and cofactor stores, shared multiplier, wide accumulator,
// restoring divider and result register.
// ----------------------------------------------------------------------------
module minv4_dpath
    import minv4_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] element,
    input  dp_cmd_t     cmd,
    output dp_status_t  sts,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] value,
    output logic        singular,
    output logic        last
);

    localparam int DW     = DATA_WIDTH;
    localparam int MUL_W  = DW + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int COF_W  = 3 * DW + 3;
    localparam int ACC_W  = 4 * DW + 5;
    localparam int EXT_W  = 4 * DW;
    localparam int NUM_W  = COF_W + 2 * FRAC_BITS;
    localparam int CMP_W  = (NUM_W > ACC_W + DW) ? NUM_W : ACC_W + DW;

    logic [DW-1:0]           rd_a;
    logic [DW-1:0]           rd_b;
    logic [COF_W-1:0]        cof_rd;

    logic signed [MUL_W-1:0]  op_a;
    logic signed [MUL_W-1:0]  op_b;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [PROD_W-1:0] prod_reg;
    logic [1:0]               prod_limb_reg;
    logic [MUL_W-1:0]         m_limb;
    logic [EXT_W-1:0]         cof_ext;
    logic [DW-1:0]            cl;
    logic [MUL_W-1:0]         c_limb;

    logic [2*DW-1:0]          m_reg;
    logic [DW-1:0]            ea_reg;

    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  prod_sh;

    logic [ACC_W-1:0]         det_mag_reg;
    logic                     det_neg_reg;

    logic                     cof_neg;
    logic [COF_W-1:0]         cof_mag;
    logic [NUM_W-1:0]         num_reg;
    logic                     neg_reg;
    logic                     ovf_reg;
    logic [ACC_W-1:0]         rem_reg;
    logic [DW-1:0]            low_reg;
    logic [DW-1:0]            q_reg;
    logic [CMP_W-1:0]         num_c;
    logic [CMP_W-1:0]         den_c;
    logic [ACC_W:0]           rem2;
    logic [ACC_W:0]           rem_diff;
    logic [DW-1:0]            lim;
    logic signed [DW-1:0]     res;

    logic                     out_valid_reg;
    logic [31:0]              value_reg;
    logic                     singular_reg;
    logic                     last_reg;

    // Two element copies give two reads per cycle
    minv4_ram #(.WIDTH(DW), .DEPTH(NUM_ELEM)) u_elem_a (
        .clk   (clk),
        .we    (cmd.elem_we),
        .waddr (cmd.elem_addr),
        .wdata (element[DW-1:0]),
        .raddr (cmd.addr_a),
        .rdata (rd_a)
    );

    minv4_ram #(.WIDTH(DW), .DEPTH(NUM_ELEM)) u_elem_b (
        .clk   (clk),
        .we    (cmd.elem_we),
        .waddr (cmd.elem_addr),
        .wdata (element[DW-1:0]),
        .raddr (cmd.addr_b),
        .rdata (rd_b)
    );

    minv4_ram #(.WIDTH(COF_W), .DEPTH(NUM_ELEM)) u_cof (
        .clk   (clk),
        .we    (cmd.cof_we),
        .waddr (cmd.cof_waddr),
        .wdata (acc_reg[COF_W-1:0]),
        .raddr (cmd.cof_raddr),
        .rdata (cof_rd)
    );

    // Multiplier operand selection: low limbs unsigned, top limb signed
    always_comb
    begin
        m_limb  = cmd.limb[0] ? {m_reg[2*DW-1], m_reg[2*DW-1:DW]} : {1'b0, m_reg[DW-1:0]};
        cof_ext = {{(EXT_W - COF_W){cof_rd[COF_W-1]}}, cof_rd};
        case (cmd.limb)
            2'd0:    cl = cof_ext[DW-1:0];
            2'd1:    cl = cof_ext[2*DW-1:DW];
            2'd2:    cl = cof_ext[3*DW-1:2*DW];
            default: cl = cof_ext[4*DW-1:3*DW];
        endcase
        c_limb = (cmd.limb == 2'd3) ? {cl[DW-1], cl} : {1'b0, cl};
        case (cmd.mul_sel)
            MUL_ELEM:
            begin
                op_a = {rd_a[DW-1], rd_a};
                op_b = {rd_b[DW-1], rd_b};
            end
            MUL_MLIMB:
            begin
                op_a = m_limb;
                op_b = {ea_reg[DW-1], ea_reg};
            end
            MUL_CLIMB:
            begin
                op_a = c_limb;
                op_b = {rd_a[DW-1], rd_a};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        prod_c = op_a * op_b;
    end

    // Accumulate the registered product at its limb weight
    always_comb
    begin
        prod_ext = ACC_W'(prod_reg);
        case (prod_limb_reg)
            2'd0:    prod_sh = prod_ext;
            2'd1:    prod_sh = prod_ext <<< DW;
            2'd2:    prod_sh = prod_ext <<< (2 * DW);
            default: prod_sh = prod_ext <<< (3 * DW);
        endcase
        case (cmd.acc_op)
            ACC_CLEAR: acc_next = '0;
            ACC_ADD:   acc_next = acc_reg + prod_sh;
            ACC_SUB:   acc_next = acc_reg - prod_sh;
            default:   acc_next = acc_reg;
        endcase
    end

    // Divider arithmetic
    always_comb
    begin
        cof_neg  = cof_rd[COF_W-1];
        cof_mag  = cof_neg ? (~cof_rd + 1'b1) : cof_rd;
        num_c    = CMP_W'(num_reg);
        den_c    = CMP_W'(det_mag_reg) << DW;
        rem2     = {rem_reg, low_reg[DW-1]};
        rem_diff = rem2 - {1'b0, det_mag_reg};
        lim      = neg_reg ? {1'b1, {(DW - 1){1'b0}}} : {1'b0, {(DW - 1){1'b1}}};
        if (ovf_reg || (q_reg > lim))
        begin
            res = lim;
        end
        else
        begin
            res = neg_reg ? (~q_reg + 1'b1) : q_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_c;
        prod_limb_reg <= cmd.limb;
        acc_reg       <= acc_next;
        if (cmd.latch_m)
        begin
            m_reg  <= prod_reg[2*DW-1:0];
            ea_reg <= rd_a;
        end
        if (cmd.det_latch)
        begin
            det_neg_reg <= acc_reg[ACC_W-1];
            det_mag_reg <= acc_reg[ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;
        end
        if (cmd.div_load)
        begin
            num_reg <= NUM_W'(cof_mag) << (2 * FRAC_BITS);
            neg_reg <= cof_neg ^ det_neg_reg;
        end
        if (cmd.div_start)
        begin
            ovf_reg <= (num_c >= den_c);
            rem_reg <= ACC_W'(num_c >> DW);
            low_reg <= num_reg[DW-1:0];
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem2 >= {1'b0, det_mag_reg})
            begin
                rem_reg <= rem_diff[ACC_W-1:0];
                q_reg   <= {q_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem2[ACC_W-1:0];
                q_reg   <= {q_reg[DW-2:0], 1'b0};
            end
            low_reg <= low_reg << 1;
        end
        if (cmd.out_load)
        begin
            value_reg    <= cmd.out_singular ? 32'd0 : 32'(res);
            singular_reg <= cmd.out_singular;
            last_reg     <= cmd.out_last;
        end
    end

    // Result register valid: set on load, drop once the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.det_zero = (acc_reg == '0);
    assign sts.out_free = !out_valid_reg || !result_stall;

    assign result_valid = out_valid_reg;
    assign value        = value_reg;
    assign singular     = singular_reg;
    assign last         = last_reg;

endmodule

[rtl/minv4_ctrl.sv]
// ----------------------------------------------------------------------------
// minv4_ctrl
// Sequencer: loading, cofactor terms, determinant, division and output.
// ----------------------------------------------------------------------------
module minv4_ctrl
    import minv4_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    output dp_cmd_t    cmd,
    input  dp_status_t sts
);

    localparam int STEP_W = $clog2(DATA_WIDTH);

    ctrl_state_t       state_reg;
    ctrl_state_t       state_next;
    logic [3:0]        load_cnt_reg;
    logic [3:0]        load_cnt_next;
    logic [3:0]        k_reg;
    logic [3:0]        k_next;
    logic [2:0]        term_reg;
    logic [2:0]        term_next;
    logic [1:0]        limb_reg;
    logic [1:0]        limb_next;
    logic [1:0]        row_reg;
    logic [1:0]        row_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    term_info_t        ti;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            k_reg        <= '0;
            term_reg     <= '0;
            limb_reg     <= '0;
            row_reg      <= '0;
            step_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            k_reg        <= k_next;
            term_reg     <= term_next;
            limb_reg     <= limb_next;
            row_reg      <= row_next;
            step_reg     <= step_next;
        end
    end

    always_comb
    begin
        ti            = term_info(k_reg, term_reg);
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        k_next        = k_reg;
        term_next     = term_reg;
        limb_next     = limb_reg;
        row_next      = row_reg;
        step_next     = step_reg;
        item_stall    = 1'b1;
        cmd           = '0;
        cmd.mul_sel   = MUL_ELEM;
        cmd.acc_op    = ACC_HOLD;

        case (state_reg)
            ST_LOAD:
            begin
                item_stall    = 1'b0;
                cmd.acc_op    = ACC_CLEAR;
                cmd.elem_we   = item_valid;
                cmd.elem_addr = load_cnt_reg;
                if (item_valid)
                begin
                    load_cnt_next = load_cnt_reg + 4'd1;
                    if (load_cnt_reg == 4'(NUM_ELEM - 1))
                    begin
                        k_next     = '0;
                        term_next  = '0;
                        state_next = ST_TRD;
                    end
                end
            end
            ST_TRD:
            begin
                cmd.addr_a = ti.b;
                cmd.addr_b = ti.c;
                state_next = ST_TMUL;
            end
            ST_TMUL:
            begin
                cmd.mul_sel = MUL_ELEM;
                cmd.addr_a  = ti.a;
                state_next  = ST_TLATCH;
            end
            ST_TLATCH:
            begin
                cmd.latch_m = 1'b1;
                state_next  = ST_TML0;
            end
            ST_TML0:
            begin
                cmd.mul_sel = MUL_MLIMB;
                cmd.limb    = 2'd0;
                state_next  = ST_TML1;
            end
            ST_TML1:
            begin
                cmd.acc_op  = ti.neg ? ACC_SUB : ACC_ADD;
                cmd.mul_sel = MUL_MLIMB;
                cmd.limb    = 2'd1;
                state_next  = ST_TACC1;
            end
            ST_TACC1:
            begin
                cmd.acc_op = ti.neg ? ACC_SUB : ACC_ADD;
                if (term_reg == 3'(NUM_TERM - 1))
                begin
                    state_next = ST_CWR;
                end
                else
                begin
                    term_next  = term_reg + 3'd1;
                    state_next = ST_TRD;
                end
            end
            ST_CWR:
            begin
                cmd.cof_we    = 1'b1;
                cmd.cof_waddr = k_reg;
                cmd.acc_op    = ACC_CLEAR;
                term_next     = '0;
                if (k_reg == 4'(NUM_ELEM - 1))
                begin
                    k_next     = '0;
                    row_next   = '0;
                    limb_next  = '0;
                    state_next = ST_DRD;
                end
                else
                begin
                    k_next     = k_reg + 4'd1;
                    state_next = ST_TRD;
                end
            end
            ST_DRD:
            begin
                cmd.addr_a    = {2'b00, row_reg};
                cmd.cof_raddr = {row_reg, 2'b00};
                state_next    = ST_DMUL;
            end
            ST_DMUL:
            begin
                cmd.addr_a    = {2'b00, row_reg};
                cmd.cof_raddr = {row_reg, 2'b00};
                cmd.mul_sel   = MUL_CLIMB;
                cmd.limb      = limb_reg;
                state_next    = ST_DACC;
            end
            ST_DACC:
            begin
                cmd.addr_a    = {2'b00, row_reg};
                cmd.cof_raddr = {row_reg, 2'b00};
                cmd.acc_op    = ACC_ADD;
                if (limb_reg == 2'd3)
                begin
                    limb_next = '0;
                    if (row_reg == 2'd3)
                    begin
                        state_next = ST_DCHK;
                    end
                    else
                    begin
                        row_next   = row_reg + 2'd1;
                        state_next = ST_DRD;
                    end
                end
                else
                begin
                    limb_next  = limb_reg + 2'd1;
                    state_next = ST_DMUL;
                end
            end
            ST_DCHK:
            begin
                cmd.det_latch = 1'b1;
                k_next        = '0;
                state_next    = sts.det_zero ? ST_SING : ST_VRD;
            end
            ST_SING:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load     = 1'b1;
                    cmd.out_singular = 1'b1;
                    cmd.out_last     = 1'b1;
                    state_next       = ST_LOAD;
                end
            end
            ST_VRD:
            begin
                cmd.cof_raddr = k_reg;
                state_next    = ST_VLOAD;
            end
            ST_VLOAD:
            begin
                cmd.cof_raddr = k_reg;
                cmd.div_load  = 1'b1;
                state_next    = ST_VCMP;
            end
            ST_VCMP:
            begin
                cmd.div_start = 1'b1;
                step_next     = '0;
                state_next    = ST_VSTEP;
            end
            ST_VSTEP:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == STEP_W'(DATA_WIDTH - 1))
                begin
                    state_next = ST_VOUT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_VOUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = (k_reg == 4'(NUM_ELEM - 1));
                    if (k_reg == 4'(NUM_ELEM - 1))
                    begin
                        k_next     = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + 4'd1;
                        state_next = ST_VRD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

[rtl/matrix_inverse_4x4_unit.sv]
// Sequence: after the sixteenth element beat the unit forms all sixteen cofactors,
//   then the determinant, then one quotient per result beat; a singular matrix
//   shows its single beat once the determinant is found to be zero.
// Throughput: no new matrix is taken until the last result beat is loaded; the rate
//   is set by the single shared multiplier and the one-bit-per-cycle restoring divider.
// Reset: asynchronous, active low; load position returns to the first element.
// ----------------------------------------------------------------------------
// matrix_inverse_4x4_unit
// 4x4 fixed-point inverse by adjugate over determinant; one beat per element, one if singular.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix_inverse_4x4_unit
    import minv4_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [31:0] element,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] value,
    output logic        singular,
    output logic        last
);

    // Controller to datapath commands and status
    dp_cmd_t    cmd;
    dp_status_t sts;

    // Sequencer: hold the input while a matrix is in work, advance through
    // cofactors, determinant and quotients
    minv4_ctrl #(.DATA_WIDTH(DATA_WIDTH)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .cmd        (cmd),
        .sts        (sts)
    );

    // Datapath: element stores, shared multiplier, accumulator, divider and
    // the result register that decouples the output side
    minv4_dpath #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .element      (element),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .value        (value),
        .singular     (singular),
        .last         (last)
    );

    // Cofactor writes only happen while input is held off
    `ASSERT_IMPLIES(a_cof_we_busy, clk, rst_n, cmd.cof_we, item_stall, "cofactor write during load")
    // Never overwrite a result beat that is still waiting
    `ASSERT_IMPLIES(a_out_load_free, clk, rst_n, cmd.out_load, sts.out_free, "result beat overwritten")
    // A loaded result shows up as a valid beat
    `ASSERT_NEXT(a_out_load_valid, clk, rst_n, cmd.out_load, result_valid, "loaded beat not shown")
    // A singular beat is the only and last beat, with zero value
    `ASSERT_IMPLIES(a_singular_form, clk, rst_n, result_valid && singular, last && (value == 32'd0), "bad singular beat")

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams 4x4 Q16.16 matrices into matrix_inverse_4x4_unit and checks every
// inverse beat against an exact signed 256-bit adjugate/determinant predictor
// or, for three directed matrices, fixed expected beats. Directed matrices
// come first, then random ones, under several idle and stall mixes.
// ----------------------------------------------------------------------------
module testbench;
    import minv4_pkg::*;

    localparam int FRAC   = 16;
    localparam int WDOG   = 40000;
    localparam int TAIL   = 1500;
    localparam int N_RAND = 9;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        logic [31:0] value;
        logic        singular;
        logic        last;
    } inv_beat_t;

    // Directed stimulus: one row per element beat, grouped in matrices
    typedef enum int { CHK_PRED, CHK_ZERO, CHK_IDENT, CHK_SAT } chk_kind_t;
    typedef struct {
        logic [31:0] elem;
        chk_kind_t   kind;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic [31:0] element = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [31:0] value;
    logic        singular;
    logic        last;

    logic signed [31:0] mat_copy [16];
    int unsigned        mat_fill;
    inv_beat_t          inverse_q [$];
    int                 fail_count = 0;
    int                 idle_pct = 0;
    int                 stall_pct = 0;
    int                 quiet_cycles = 0;
    stim_row_t          dir_tab [$];

    matrix_inverse_4x4_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .element      (element),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .value        (value),
        .singular     (singular),
        .last         (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Signed cofactor of row r, column c of the held matrix
    function automatic wide_t cofactor_of(int r, int c);
        wide_t e [3][3];
        wide_t acc;
        int    rs [3];
        int    cs [3];
        int    n;
        n = 0;
        for (int i = 0; i < 4; i++)
            if (i != r)
            begin
                rs[n] = i;
                n++;
            end
        n = 0;
        for (int i = 0; i < 4; i++)
            if (i != c)
            begin
                cs[n] = i;
                n++;
            end
        for (int i = 0; i < 9; i++)
            e[i / 3][i % 3] = wide_t'(mat_copy[rs[i / 3] * 4 + cs[i % 3]]);
        acc = e[0][0] * (e[1][1] * e[2][2] - e[1][2] * e[2][1])
            - e[0][1] * (e[1][0] * e[2][2] - e[1][2] * e[2][0])
            + e[0][2] * (e[1][0] * e[2][1] - e[1][1] * e[2][0]);
        if (((r + c) & 1) != 0)
            acc = -acc;
        return acc;
    endfunction

    // Truncating divide of adj * 2^(2F) by det, saturated to 32 bits
    function automatic logic [31:0] scaled_quotient(wide_t num, wide_t den);
        logic [255:0] mn;
        logic [255:0] md;
        logic [255:0] q;
        logic [255:0] lim;
        logic         neg;
        neg = num[255] ^ den[255];
        mn  = num[255] ? -num : num;
        md  = den[255] ? -den : den;
        mn  = mn << (2 * FRAC);
        q   = mn / md;
        lim = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
        if (q > lim)
            q = lim;
        return neg ? 32'(-q) : q[31:0];
    endfunction

    // Hold one element; on the sixteenth, queue the inverse beats if asked
    task automatic absorb_element(logic [31:0] e, bit queue_it);
        wide_t adj [16];
        wide_t det;
        mat_copy[mat_fill] = e;
        if (mat_fill != 15)
        begin
            mat_fill++;
            return;
        end
        mat_fill = 0;
        if (!queue_it)
            return;
        for (int i = 0; i < 16; i++)
            adj[(i & 3) * 4 + (i >> 2)] = cofactor_of(i >> 2, i & 3);
        det = '0;
        for (int i = 0; i < 4; i++)
            det = det + adj[i * 4] * wide_t'(mat_copy[i]);
        if (det == 0)
            inverse_q.push_back('{32'd0, 1'b1, 1'b1});
        else
            for (int i = 0; i < 16; i++)
                inverse_q.push_back('{scaled_quotient(adj[i], det), 1'b0, i == 15});
    endtask

    // Drive one element beat and hold it until accepted
    task automatic send_element(logic [31:0] e, bit queue_it);
        int gap;
        if ($urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(1, 6);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        element    <= e;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        absorb_element(e, queue_it);
    endtask

    function automatic logic [31:0] random_element(int style);
        case (style)
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 16)) - 8) <<< FRAC;
            2:       return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 8;
            default: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : $urandom;
        endcase
    endfunction

    // Response side: check beats, drive stall, run the watchdog
    always @(posedge clk)
    begin
        inverse_q_check : begin
            inverse_q_check_body();
        end
    end

    task automatic inverse_q_check_body();
        inv_beat_t want;
        if (!rst_n)
            return;
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WDOG)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (result_valid && !result_stall)
        begin
            if (inverse_q.size() == 0)
            begin
                $error("unexpected result beat: value %h", value);
                fail_count++;
            end
            else
            begin
                want = inverse_q.pop_front();
                if (value !== want.value)
                begin
                    $error("value: expected %h, got %h", want.value, value);
                    fail_count++;
                end
                if (singular !== want.singular)
                begin
                    $error("singular: expected %b, got %b", want.singular, singular);
                    fail_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, last);
                    fail_count++;
                end
            end
        end
        result_stall <= ($urandom_range(99) < stall_pct);
    endtask

    initial
    begin
        logic signed [31:0] row_a [4];
        int                 style;
        mat_fill = 0;
        // Zero matrix: singular; identity: exact; raw-unit diagonal: saturates
        for (int i = 0; i < 16; i++)
            dir_tab.push_back('{32'd0, CHK_ZERO});
        for (int i = 0; i < 16; i++)
            dir_tab.push_back('{(i % 5 == 0) ? 32'h0001_0000 : 32'd0, CHK_IDENT});
        for (int i = 0; i < 16; i++)
            dir_tab.push_back('{(i % 5 == 0) ? 32'd1 : 32'd0, CHK_SAT});
        // Full-range extremes on the diagonal, predicted
        for (int i = 0; i < 16; i++)
            dir_tab.push_back('{(i == 0) ? 32'h7FFF_FFFF : (i == 5) ? 32'h8000_0000 :
                                (i == 10) ? 32'hFFFF_FFFF : (i == 15) ? 32'h0000_0001 :
                                32'd0, CHK_PRED});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            send_element(dir_tab[i].elem, dir_tab[i].kind == CHK_PRED);
            if (i % 16 == 15)
                case (dir_tab[i].kind)
                    CHK_ZERO:  inverse_q.push_back('{32'd0, 1'b1, 1'b1});
                    CHK_IDENT, CHK_SAT:
                        for (int k = 0; k < 16; k++)
                            inverse_q.push_back('{(k % 5 != 0) ? 32'd0 :
                                (dir_tab[i].kind == CHK_IDENT) ? 32'h0001_0000 :
                                32'h7FFF_FFFF, 1'b0, k == 15});
                    default: ;
                endcase
        end

        for (int m = 0; m < N_RAND; m++)
        begin
            // New idle mix: drain first so the sender pauses until all is out
            if (m % 2 == 0 || m == 1)
            begin
                item_valid <= 1'b0;
                while (inverse_q.size() != 0)
                    @(posedge clk);
                case (m / 2)
                    0: begin idle_pct = 0;  stall_pct = 0;  end
                    1: begin idle_pct = 63; stall_pct = 0;  end
                    2: begin idle_pct = 0;  stall_pct = 63; end
                    default: begin idle_pct = 11; stall_pct = 11; end
                endcase
            end
            style = $urandom_range(0, 4);
            for (int i = 0; i < 16; i++)
            begin
                // Style 4: repeat row 0 into row 3 to force a singular matrix
                if (style == 4 && i >= 12)
                    send_element(row_a[i - 12], 1'b1);
                else
                begin
                    row_a[i % 4] = (i < 4) ? random_element(m % 4) : row_a[i % 4];
                    send_element((i < 4) ? row_a[i] : random_element(m % 4), 1'b1);
                end
            end
        end

        item_valid <= 1'b0;
        while (inverse_q.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
